@@ hdl/stepper_joint_position_controller_unit_assert.svh @@
// Assertion macros shared by the checker of the stepper joint controller.
`ifndef STEPPER_JOINT_POSITION_CONTROLLER_UNIT_ASSERT_SVH
`define STEPPER_JOINT_POSITION_CONTROLLER_UNIT_ASSERT_SVH

// Checked at every rising edge once reset is released.
`define SJPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define SJPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/sjpc_pkg.sv @@
// Types and constants of the stepper joint position controller.
package sjpc_pkg;

  // Input kinds.
  localparam logic [1:0] KIND_SEED   = 2'd0;
  localparam logic [1:0] KIND_TICK   = 2'd1;
  localparam logic [1:0] KIND_TARGET = 2'd2;
  localparam logic [1:0] KIND_STEP   = 2'd3;

  // Joint modes.
  localparam logic [1:0] MODE_INITED  = 2'd0;
  localparam logic [1:0] MODE_MOVING  = 2'd1;
  localparam logic [1:0] MODE_HOLDING = 2'd2;

  // What the control-law stages do with an item.
  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_SEED   = 2'd1;
  localparam logic [1:0] EV_TICK   = 2'd2;
  localparam logic [1:0] EV_TARGET = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_GAIN_P    = 3'd0;
  localparam logic [2:0] REG_GAIN_I    = 3'd1;
  localparam logic [2:0] REG_GAIN_D    = 3'd2;
  localparam logic [2:0] REG_BACKLASH  = 3'd3;
  localparam logic [2:0] REG_SETTLE    = 3'd4;
  localparam logic [2:0] REG_INVERT    = 3'd5;

  localparam logic [3:0] PHASE_START = 4'hC;

  typedef struct packed {
    logic [30:0] gain_p;
    logic [30:0] gain_i;
    logic [30:0] gain_d;
    logic [13:0] backlash_counts;
    logic [15:0] settle_threshold;
    logic        invert_direction;
  } cfg_t;

  // Item handed from the state stage to the control-law stages.
  typedef struct packed {
    logic [1:0]         ev;
    logic [3:0]         phase;
    logic [31:0]        position;
    logic signed [31:0] err;
    logic signed [32:0] diff;
  } law_req_t;

  // Result item, laid out exactly as the output tdata.
  typedef struct packed {
    logic        pad;
    logic [1:0]  joint_state;
    logic [31:0] position;
    logic        step_direction;
    logic [15:0] step_count;
    logic [3:0]  phase_pattern;
  } out_item_t;

endpackage

@@ hdl/stepper_joint_position_controller_unit.sv @@
// Stepper joint position controller: a state stage followed by three control-law
// stages. One request is taken every cycle while the result side keeps up. The
// pipeline registers move together, so a result held back by out_tready stops
// the whole pipeline, and the depth is set by the gain multipliers, the 65-bit
// saturating sum and the magnitude compare, each of which has a stage of its
// own. Configuration writes take effect at once and should be made while no
// request is in flight.
module stepper_joint_position_controller_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // angle[13:0], target_value[45:14], step_clockwise[46], halted[47]
  input  logic [47:0] in_tdata,
  // kind[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // phase_pattern[3:0], step_count[19:4], step_direction[20], position[52:21],
  // joint_state[54:53], zero[55]
  output logic [55:0] out_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [30:0] cfg_wdata
);
  import sjpc_pkg::*;

  cfg_t      cfg_r;
  logic      en;
  logic      req_valid;
  law_req_t  req;
  out_item_t out_item;

  assign en        = ~out_tvalid | out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p           <= 31'd763;
      cfg_r.gain_i           <= 31'd0;
      cfg_r.gain_d           <= 31'd0;
      cfg_r.backlash_counts  <= 14'd0;
      cfg_r.settle_threshold <= 16'd5;
      cfg_r.invert_direction <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_GAIN_P:   cfg_r.gain_p           <= cfg_wdata;
        REG_GAIN_I:   cfg_r.gain_i           <= cfg_wdata;
        REG_GAIN_D:   cfg_r.gain_d           <= cfg_wdata;
        REG_BACKLASH: cfg_r.backlash_counts  <= cfg_wdata[13:0];
        REG_SETTLE:   cfg_r.settle_threshold <= cfg_wdata[15:0];
        REG_INVERT:   cfg_r.invert_direction <= cfg_wdata[0];
        default:      cfg_r                  <= cfg_r;
      endcase
    end
  end

  sjpc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .in_kind   (in_tuser),
    .in_data   (in_tdata),
    .cfg       (cfg_r),
    .req_valid (req_valid),
    .req       (req)
  );

  sjpc_law u_law (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .req_valid (req_valid),
    .req       (req),
    .cfg       (cfg_r),
    .out_valid (out_tvalid),
    .out_item  (out_item)
  );

  assign out_tdata = out_item;

endmodule

@@ hdl/sjpc_front.sv @@
// Input register and joint state update: angle tracking, phases, target and error.
module sjpc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [1:0]        in_kind,
  input  logic [47:0]       in_data,
  input  sjpc_pkg::cfg_t    cfg,
  output logic              req_valid,
  output sjpc_pkg::law_req_t req
);
  import sjpc_pkg::*;

  localparam logic signed [14:0] UNWRAP_LIMIT = 15'sd13653;
  localparam logic signed [15:0] TURN_COUNTS  = 16'sd16384;

  function automatic logic [3:0] rotate_phase(input logic [3:0] p);
    rotate_phase = {p[0], p[3:1]};
  endfunction

  function automatic logic [3:0] reverse4(input logic [3:0] p);
    reverse4 = {p[0], p[1], p[2], p[3]};
  endfunction

  // Input register.
  logic               in_v_r;
  logic [1:0]         kind_r;
  logic [13:0]        angle_r;
  logic signed [31:0] tval_r;
  logic               cw_r;
  logic               halt_r;

  // Joint state.
  logic [3:0]         cw_phase_r, cw_phase_nxt;
  logic [3:0]         ccw_phase_r, ccw_phase_nxt;
  logic [3:0]         coil_r, coil_nxt;
  logic [13:0]        last_angle_r, last_angle_nxt;
  logic signed [31:0] pos_r, pos_nxt;
  logic signed [31:0] tgt_pos_r, tgt_pos_nxt;
  logic signed [31:0] prev_err_r, prev_err_nxt;
  logic               turn_up_r, turn_up_nxt;

  logic               req_v_r;
  law_req_t           req_r, req_nxt;

  logic signed [14:0] d_raw;
  logic signed [15:0] d_step;
  logic signed [31:0] pos_tick, pos_step;
  logic signed [32:0] err_wide;
  logic signed [31:0] err;
  logic signed [32:0] bl_up, bl_dn;
  logic               add_rule;
  logic               upd;

  assign upd = en & in_v_r;

  always_comb begin
    d_raw    = $signed({1'b0, angle_r}) - $signed({1'b0, last_angle_r});
    pos_tick = pos_r + {{17{d_raw[14]}}, d_raw};

    // Error against the position after this tick, held to 32 signed bits.
    err_wide = {tgt_pos_r[31], tgt_pos_r} - {pos_tick[31], pos_tick};
    if (err_wide[32] != err_wide[31]) begin
      err = err_wide[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      err = err_wide[31:0];
    end

    // The unwrap seam sits at 300 of 360 degrees in the turning sense.
    add_rule = cw_r ^ cfg.invert_direction;
    d_step   = {d_raw[14], d_raw};
    if (add_rule && (d_raw < -UNWRAP_LIMIT)) begin
      d_step = d_step + TURN_COUNTS;
    end else if (!add_rule && (d_raw > UNWRAP_LIMIT)) begin
      d_step = d_step - TURN_COUNTS;
    end
    pos_step = pos_r + {{16{d_step[15]}}, d_step};

    bl_up = {tval_r[31], tval_r} + {19'd0, cfg.backlash_counts};
    bl_dn = {tval_r[31], tval_r} - {19'd0, cfg.backlash_counts};
  end

  always_comb begin
    cw_phase_nxt   = cw_phase_r;
    ccw_phase_nxt  = ccw_phase_r;
    coil_nxt       = coil_r;
    last_angle_nxt = last_angle_r;
    pos_nxt        = pos_r;
    tgt_pos_nxt    = tgt_pos_r;
    prev_err_nxt   = prev_err_r;
    turn_up_nxt    = turn_up_r;
    req_nxt.ev     = EV_NONE;
    req_nxt.err    = err;
    req_nxt.diff   = {err[31], err} - {prev_err_r[31], prev_err_r};

    unique case (kind_r)
      KIND_SEED: begin
        last_angle_nxt = angle_r;
        req_nxt.ev     = EV_SEED;
      end
      KIND_TICK: begin
        last_angle_nxt = angle_r;
        pos_nxt        = pos_tick;
        if (!halt_r) begin
          prev_err_nxt = err;
          req_nxt.ev   = EV_TICK;
        end
      end
      KIND_TARGET: begin
        tgt_pos_nxt = tval_r;
        req_nxt.ev  = EV_TARGET;
        if (tval_r > pos_r) begin
          turn_up_nxt = 1'b1;
          if (!turn_up_r) begin
            tgt_pos_nxt = (bl_up[32] != bl_up[31]) ? 32'sh7FFF_FFFF : bl_up[31:0];
          end
        end else if (tval_r < pos_r) begin
          turn_up_nxt = 1'b0;
          if (turn_up_r) begin
            tgt_pos_nxt = (bl_dn[32] != bl_dn[31]) ? 32'sh8000_0000 : bl_dn[31:0];
          end
        end
      end
      KIND_STEP: begin
        if (!halt_r) begin
          if (cw_r) begin
            coil_nxt     = cw_phase_r;
            cw_phase_nxt = rotate_phase(cw_phase_r);
          end else begin
            coil_nxt      = reverse4(ccw_phase_r);
            ccw_phase_nxt = rotate_phase(ccw_phase_r);
          end
          pos_nxt        = pos_step;
          last_angle_nxt = angle_r;
        end
      end
      default: begin
        req_nxt.ev = EV_NONE;
      end
    endcase

    req_nxt.phase    = coil_nxt;
    req_nxt.position = pos_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r       <= 1'b0;
      req_v_r      <= 1'b0;
      cw_phase_r   <= PHASE_START;
      ccw_phase_r  <= PHASE_START;
      coil_r       <= 4'h0;
      last_angle_r <= '0;
      pos_r        <= '0;
      tgt_pos_r    <= '0;
      prev_err_r   <= '0;
      turn_up_r    <= 1'b1;
    end else begin
      if (en) begin
        in_v_r  <= in_valid;
        req_v_r <= in_v_r;
      end
      if (upd) begin
        cw_phase_r   <= cw_phase_nxt;
        ccw_phase_r  <= ccw_phase_nxt;
        coil_r       <= coil_nxt;
        last_angle_r <= last_angle_nxt;
        pos_r        <= pos_nxt;
        tgt_pos_r    <= tgt_pos_nxt;
        prev_err_r   <= prev_err_nxt;
        turn_up_r    <= turn_up_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind_r  <= in_kind;
      angle_r <= in_data[13:0];
      tval_r  <= in_data[45:14];
      cw_r    <= in_data[46];
      halt_r  <= in_data[47];
      req_r   <= req_nxt;
    end
  end

  assign req_valid = req_v_r;
  assign req       = req_r;

endmodule

@@ hdl/sjpc_law.sv @@
// Control law stages: gain products, saturated drive, step count and joint mode.
module sjpc_law (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                req_valid,
  input  sjpc_pkg::law_req_t  req,
  input  sjpc_pkg::cfg_t      cfg,
  output logic                out_valid,
  output sjpc_pkg::out_item_t out_item
);
  import sjpc_pkg::*;

  localparam logic signed [64:0] DRIVE_MAX = 65'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] DRIVE_MIN = -DRIVE_MAX;

  // Product stage.
  logic               v2_r;
  logic [1:0]         ev2_r;
  logic [3:0]         phase2_r;
  logic [31:0]        pos2_r;
  logic signed [63:0] t1_r, t1_nxt;
  logic signed [63:0] t2_r, t2_nxt;

  // Sum stage.
  logic               v3_r;
  logic [1:0]         ev3_r;
  logic [3:0]         phase3_r;
  logic [31:0]        pos3_r;
  logic signed [63:0] drive_r, drive_nxt;

  // Result stage.
  logic               out_v_r;
  logic [1:0]         mode_r, mode_nxt;
  logic [3:0]         phase_r;
  logic [15:0]        count_r, count_nxt;
  logic               dir_r, dir_nxt;
  logic [31:0]        pos_r;

  logic [31:0]        gain_sum;
  logic signed [32:0] op_a1, op_a2, op_err;
  logic signed [65:0] prod1, prod2;
  logic signed [64:0] sum;
  logic [63:0]        mag;
  logic               settled;

  always_comb begin
    // Proportional and present-error integral share one product.
    gain_sum = {1'b0, cfg.gain_p} + {1'b0, cfg.gain_i};
    op_a1    = {1'b0, gain_sum};
    op_a2    = {2'b00, cfg.gain_d};
    op_err   = {req.err[31], req.err};
    prod1    = op_a1 * op_err;
    prod2    = op_a2 * req.diff;
    t1_nxt   = prod1[63:0];
    t2_nxt   = prod2[63:0];
  end

  always_comb begin
    sum = {t1_r[63], t1_r} + {t2_r[63], t2_r};
    if (sum > DRIVE_MAX) begin
      drive_nxt = DRIVE_MAX[63:0];
    end else if (sum < DRIVE_MIN) begin
      drive_nxt = DRIVE_MIN[63:0];
    end else begin
      drive_nxt = sum[63:0];
    end
  end

  always_comb begin
    mag       = drive_r[63] ? (64'd0 - drive_r) : drive_r;
    settled   = mag < {32'd0, cfg.settle_threshold, 16'd0};
    count_nxt = 16'd0;
    dir_nxt   = 1'b0;
    mode_nxt  = mode_r;
    unique case (ev3_r)
      EV_SEED:   mode_nxt = MODE_INITED;
      EV_TARGET: mode_nxt = MODE_MOVING;
      EV_TICK: begin
        count_nxt = (|mag[63:32]) ? 16'hFFFF : mag[31:16];
        if (drive_r != 64'sd0) begin
          dir_nxt = drive_r[63] ? cfg.invert_direction : ~cfg.invert_direction;
        end
        if ((mode_r == MODE_MOVING) && settled) begin
          mode_nxt = MODE_HOLDING;
        end
      end
      EV_NONE:   mode_nxt = mode_r;
      default:   mode_nxt = mode_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      out_v_r <= 1'b0;
      mode_r  <= MODE_INITED;
    end else if (en) begin
      v2_r    <= req_valid;
      v3_r    <= v2_r;
      out_v_r <= v3_r;
      if (v3_r) begin
        mode_r <= mode_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ev2_r    <= req.ev;
      phase2_r <= req.phase;
      pos2_r   <= req.position;
      t1_r     <= t1_nxt;
      t2_r     <= t2_nxt;
      ev3_r    <= ev2_r;
      phase3_r <= phase2_r;
      pos3_r   <= pos2_r;
      drive_r  <= drive_nxt;
      phase_r  <= phase3_r;
      pos_r    <= pos3_r;
      count_r  <= count_nxt;
      dir_r    <= dir_nxt;
    end
  end

  assign out_valid = out_v_r;

  always_comb begin
    out_item.pad            = 1'b0;
    out_item.joint_state    = mode_r;
    out_item.position       = pos_r;
    out_item.step_direction = dir_r;
    out_item.step_count     = count_r;
    out_item.phase_pattern  = phase_r;
  end

endmodule

@@ hdl/sjpc_checker.sv @@
// Port-level checks of the stepper joint controller and their bind.
module sjpc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata
);
  `include "stepper_joint_position_controller_unit_assert.svh"

  // A result that waits keeps its contents.
  `SJPC_ASSERT(a_out_hold, (out_tvalid && !out_tready) |=> $stable(out_tdata), "result changed while stalled")

  // With no result waiting, the block takes a new request.
  `SJPC_ASSERT(a_ready_when_empty, !out_tvalid |-> in_tready, "not ready with empty output")

  // The coil pattern is either off or has exactly two coils on.
  `SJPC_ASSERT(a_phase_shape, out_tvalid |-> (out_tdata[3:0] == 4'h0 || $countones(out_tdata[3:0]) == 2), "bad coil pattern")

  // Reset empties the pipeline.
  `SJPC_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid, "result present after reset")

endmodule

bind stepper_joint_position_controller_unit sjpc_checker u_sjpc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ test/stepper_joint_position_controller_unit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the stepper joint position controller with a cycle-free predictor.
module stepper_joint_position_controller_unit_tb;
  import sjpc_pkg::*;

  localparam int LIMIT_CYCLES = 300000;
  // Extra edges waited once no result is outstanding, to cover any slack.
  localparam int DRAIN_CYCLES = 8;
  localparam logic signed [16:0] UNWRAP_SPAN = 17'sd13653;
  localparam logic signed [16:0] TURN_COUNTS = 17'sd16384;
  localparam logic signed [33:0] S32_MAX = 34'sd2147483647;
  localparam logic signed [33:0] S32_MIN = -34'sd2147483648;
  localparam logic signed [65:0] DRIVE_MAX = 66'sh7FFFFFFFFFFFFFFF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [13:0] angle;
    logic [31:0] target;
    logic        cw;
    logic        halted;
  } joint_cmd_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  // angle[13:0], target_value[45:14], step_clockwise[46], halted[47]
  logic [47:0] in_tdata = '0;
  // kind[1:0]
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // phase_pattern[3:0], step_count[19:4], step_direction[20], position[52:21],
  // joint_state[54:53], zero[55]
  logic [55:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [30:0] cfg_wdata = '0;

  stepper_joint_position_controller_unit u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  // Predicted joint state and the register copy it runs on.
  cfg_t               setting;
  logic [3:0]         cw_ph, ccw_ph, coil;
  logic [13:0]        last_ang;
  logic signed [31:0] pos, tgt, prev_err;
  logic               turn_up;
  logic [1:0]         mode;

  out_item_t   report_q[$];
  int          errors = 0;
  longint      cycles = 0;
  int          send_idle_pct = 17;
  int          recv_idle_pct = 73;
  // Rough encoder and position tracking used only to shape random requests.
  logic [13:0]        enc = '0;
  logic signed [31:0] pos_guess = '0;

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic void reset_model();
    setting = '0;
    setting.gain_p = 31'd763;
    setting.settle_threshold = 16'd5;
    cw_ph = PHASE_START;
    ccw_ph = PHASE_START;
    coil = '0;
    last_ang = '0;
    pos = '0;
    tgt = '0;
    prev_err = '0;
    turn_up = 1'b1;
    mode = MODE_INITED;
  endfunction

  function automatic out_item_t predict_report(input joint_cmd_t c);
    out_item_t          r;
    logic signed [16:0] d;
    logic signed [33:0] wide;
    logic signed [31:0] err;
    logic signed [65:0] k_sum, t1, t2, drive;
    logic [65:0]        mag, whole;
    r = '0;
    d = $signed({3'b0, c.angle}) - $signed({3'b0, last_ang});
    case (c.kind)
      KIND_SEED: begin
        last_ang = c.angle;
        mode = MODE_INITED;
      end
      KIND_TICK: begin
        // The hold tick takes the raw difference, seam crossings included.
        pos = pos + 32'(d);
        last_ang = c.angle;
        if (!c.halted) begin
          wide = 34'(tgt) - 34'(pos);
          if (wide > S32_MAX) wide = S32_MAX;
          else if (wide < S32_MIN) wide = S32_MIN;
          err = wide[31:0];
          wide = 34'(err) - 34'(prev_err);
          k_sum = {35'd0, setting.gain_p} + {35'd0, setting.gain_i};
          t1 = k_sum * 66'(err);
          t2 = $signed({35'd0, setting.gain_d}) * 66'(wide);
          drive = t1 + t2;
          if (drive > DRIVE_MAX) drive = DRIVE_MAX;
          else if (drive < -DRIVE_MAX) drive = -DRIVE_MAX;
          prev_err = err;
          mag = (drive < 0) ? -drive : drive;
          if (mode == MODE_MOVING && mag < {34'd0, setting.settle_threshold, 16'd0})
            mode = MODE_HOLDING;
          whole = mag >> 16;
          r.step_count = (whole > 66'd65535) ? 16'hFFFF : whole[15:0];
          if (drive > 0) r.step_direction = !setting.invert_direction;
          else if (drive < 0) r.step_direction = setting.invert_direction;
        end
      end
      KIND_TARGET: begin
        wide = 34'($signed(c.target));
        if ($signed(c.target) > pos) begin
          if (!turn_up) wide = wide + $signed({20'd0, setting.backlash_counts});
          turn_up = 1'b1;
        end else if ($signed(c.target) < pos) begin
          if (turn_up) wide = wide - $signed({20'd0, setting.backlash_counts});
          turn_up = 1'b0;
        end
        if (wide > S32_MAX) wide = S32_MAX;
        else if (wide < S32_MIN) wide = S32_MIN;
        tgt = wide[31:0];
        mode = MODE_MOVING;
      end
      KIND_STEP: begin
        if (!c.halted) begin
          if (c.cw) begin
            coil = cw_ph;
            cw_ph = {cw_ph[0], cw_ph[3:1]};
          end else begin
            coil = {ccw_ph[0], ccw_ph[1], ccw_ph[2], ccw_ph[3]};
            ccw_ph = {ccw_ph[0], ccw_ph[3:1]};
          end
          // The unwrap sense follows the effective rotation, not the raw request.
          if (c.cw != setting.invert_direction) begin
            if (d < -UNWRAP_SPAN) d = d + TURN_COUNTS;
          end else if (d > UNWRAP_SPAN) begin
            d = d - TURN_COUNTS;
          end
          pos = pos + 32'(d);
          last_ang = c.angle;
        end
      end
    endcase
    r.phase_pattern = coil;
    r.position = pos;
    r.joint_state = mode;
    return r;
  endfunction

  function automatic void check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s expected %0d got %0d", name, want, got);
      errors++;
    end
  endfunction

  // Results are checked before the request of the same edge is predicted.
  always @(posedge clk) begin
    out_item_t  want, got;
    joint_cmd_t cmd;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (report_q.size() == 0) begin
          $error("result 0x%h arrived with no request outstanding", out_tdata);
          errors++;
        end else begin
          want = report_q.pop_front();
          got = out_item_t'(out_tdata);
          check_field("phase_pattern", want.phase_pattern, got.phase_pattern);
          check_field("step_count", want.step_count, got.step_count);
          check_field("step_direction", want.step_direction, got.step_direction);
          check_field("position", $signed(want.position), $signed(got.position));
          check_field("joint_state", want.joint_state, got.joint_state);
        end
      end
      if (in_tvalid && in_tready) begin
        cmd.kind = in_tuser;
        cmd.angle = in_tdata[13:0];
        cmd.target = in_tdata[45:14];
        cmd.cw = in_tdata[46];
        cmd.halted = in_tdata[47];
        report_q.push_back(predict_report(cmd));
      end
    end
  end

  // Leaves in_tvalid high after the request is taken so back-to-back requests stay dense.
  task automatic send_cmd(input logic [1:0] kind, input logic [13:0] angle,
                          input logic [31:0] target, input logic cw, input logic halted);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {halted, cw, target, angle};
    do @(posedge clk); while (!in_tready);
  endtask

  // One edge first, so the request taken at the current edge is already queued.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (report_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(input cfg_t s);
    logic [2:0]  regs [6] = '{REG_GAIN_P, REG_GAIN_I, REG_GAIN_D,
                              REG_BACKLASH, REG_SETTLE, REG_INVERT};
    logic [30:0] vals [6];
    wait_drained();
    vals = '{s.gain_p, s.gain_i, s.gain_d, {17'd0, s.backlash_counts},
             {15'd0, s.settle_threshold}, {30'd0, s.invert_direction}};
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_addr <= regs[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    setting = s;
  endtask

  function automatic logic [30:0] pick_gain();
    case ($urandom_range(9))
      0: return 31'h7FFFFFFF;
      1: return '0;
      2: return 31'($urandom);
      3: return 31'($urandom_range(1 << 20));
      default: return 31'($urandom_range(4000));
    endcase
  endfunction

  function automatic cfg_t random_settings();
    cfg_t s;
    s.gain_p = pick_gain();
    s.gain_i = pick_gain();
    s.gain_d = pick_gain();
    s.backlash_counts = $urandom_range(1) ? 14'($urandom) : 14'($urandom_range(50));
    s.settle_threshold = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(40));
    s.invert_direction = 1'($urandom_range(1));
    return s;
  endfunction

  // Mostly a plausible joint: small encoder moves and targets near the position.
  task automatic send_random_cmd();
    logic [1:0]         kind;
    logic [13:0]        angle;
    logic [31:0]        target;
    logic               halted;
    logic signed [15:0] moved;
    int                 pick;
    int                 delta;
    pick = $urandom_range(99);
    kind = (pick < 5) ? KIND_SEED : (pick < 15) ? KIND_TARGET :
           (pick < 65) ? KIND_TICK : KIND_STEP;
    delta = $urandom_range(400) - 200;
    angle = ($urandom_range(9) == 0) ? 14'($urandom) : 14'(enc + delta);
    target = ($urandom_range(4) == 0) ? $urandom : pos_guess + $urandom_range(6000) - 3000;
    halted = ($urandom_range(99) < 8);
    if ($urandom_range(19) == 0) begin
      kind = 2'($urandom);
      angle = 14'($urandom);
      target = $urandom;
    end
    send_cmd(kind, angle, target, 1'($urandom_range(1)), halted);
    if (kind == KIND_TICK || (kind == KIND_STEP && !halted)) begin
      moved = $signed({2'b0, angle}) - $signed({2'b0, enc});
      pos_guess = pos_guess + 32'(moved);
    end
    if (kind != KIND_TARGET && !(kind == KIND_STEP && halted)) enc = angle;
  endtask

  // Reset values: no coil driven, initial mode, default gains.
  task automatic test_seed_and_hold();
    send_cmd(KIND_SEED, 14'd0, '0, 1'b0, 1'b1);
    send_cmd(KIND_TICK, 14'd0, '0, 1'b0, 1'b0);
    send_cmd(KIND_TARGET, 14'd0, 32'd5000, 1'b0, 1'b0);
    send_cmd(KIND_TICK, 14'd16383, '0, 1'b0, 1'b0);
    send_cmd(KIND_TICK, 14'd4000, '0, 1'b0, 1'b1);
    send_cmd(KIND_TICK, 14'd4990, '0, 1'b0, 1'b0);
  endtask

  // Coil rotation both ways and unwrap across the seam, on and just off the limit.
  task automatic test_phase_stepping();
    send_cmd(KIND_STEP, 14'd16300, '0, 1'b1, 1'b0);
    send_cmd(KIND_STEP, 14'd50, '0, 1'b1, 1'b0);
    send_cmd(KIND_STEP, 14'd16350, '0, 1'b0, 1'b0);
    send_cmd(KIND_STEP, 14'd13653, '0, 1'b1, 1'b0);
    send_cmd(KIND_STEP, 14'd0, '0, 1'b1, 1'b0);
    send_cmd(KIND_SEED, 14'd13654, '0, 1'b0, 1'b0);
    send_cmd(KIND_STEP, 14'd0, '0, 1'b1, 1'b0);
    send_cmd(KIND_STEP, 14'd9999, '0, 1'b0, 1'b1);
    send_cmd(KIND_STEP, 14'd5, '0, 1'b0, 1'b0);
  endtask

  // Largest registers: drive and target saturation, backlash on reversal, inverted sense.
  task automatic test_range_extremes();
    cfg_t s;
    s = '1;
    apply_settings(s);
    send_cmd(KIND_SEED, 14'd16000, '0, 1'b0, 1'b0);
    send_cmd(KIND_TARGET, 14'd0, 32'h7FFFFFFF, 1'b0, 1'b0);
    send_cmd(KIND_TICK, 14'd16000, '0, 1'b0, 1'b0);
    send_cmd(KIND_TARGET, 14'd0, 32'h80000000, 1'b0, 1'b0);
    send_cmd(KIND_TICK, 14'd16000, '0, 1'b0, 1'b0);
    send_cmd(KIND_TARGET, 14'd0, 32'h7FFFFFFF, 1'b0, 1'b0);
    wait_drained();
    // A target equal to the position keeps the remembered direction.
    send_cmd(KIND_TARGET, 14'd0, pos, 1'b0, 1'b0);
    send_cmd(KIND_TICK, 14'd16000, '0, 1'b0, 1'b0);
    send_cmd(KIND_STEP, 14'd10, '0, 1'b0, 1'b0);
    send_cmd(KIND_STEP, 14'd16300, '0, 1'b1, 1'b0);
  endtask

  // Zero gains and a zero threshold: no drive and a moving joint never settles.
  task automatic test_zero_gains();
    apply_settings('0);
    send_cmd(KIND_TICK, 14'd16300, '0, 1'b0, 1'b0);
  endtask

  task automatic test_random_traffic(input int sender_idle, input int receiver_idle);
    send_idle_pct = sender_idle;
    recv_idle_pct = receiver_idle;
    repeat (4) begin
      apply_settings(random_settings());
      enc = 14'($urandom);
      pos_guess = pos;
      send_cmd(KIND_SEED, enc, '0, 1'b0, 1'b0);
      repeat (70) send_random_cmd();
    end
  endtask

  initial begin
    reset_model();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_seed_and_hold();
    test_phase_stepping();
    test_range_extremes();
    test_zero_gains();
    test_random_traffic(17, 73);
    test_random_traffic(73, 17);
    test_random_traffic(0, 0);
    wait_drained();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
